/* hdl/lsbr_pkg.sv */
`default_nettype none

package lsbr_pkg;

	localparam int DATA_W = 32;
	localparam int MODE_W = 3;
	localparam int STAT_W = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// per-request outcome handed from the ring control to the result path
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              rd_used;
	} resp_t;

endpackage

`default_nettype wire

/* hdl/lifo_stack_with_bottom_insert_reverse.sv */
// fixed-depth stack of signed 32-bit words with push, pop, peek, bottom insert and reverse
// input channel s_*: s_tuser carries the mode, s_tdata the word to push or insert
// output channel m_*: one beat per request with the read word, status and entry count
// entries live in a single-port synchronous memory used as a ring; a base pointer and
// a direction flag make bottom insert and reverse pointer moves, so every mode needs at
// most one memory access, issued in the cycle the request is accepted
// the result beat passes through the memory read stage and then the output register
// throughput: one request per cycle while m_tready does not stall the output, set by
// the one memory access per request
// the input stays ready while a result waits, as long as the request stage behind it
// is empty; a request held there keeps its read data until the output frees up
// reset clears the count, base pointer and direction; memory contents are left as is
// and only written entries are ever read
// a stalled output holds its beat stable until m_tready
`default_nettype none

module lifo_stack_with_bottom_insert_reverse import lsbr_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int CW   = $clog2(DEPTH + 1),
	localparam int OW   = ((DATA_W + CW + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,   // data_in
	input  wire logic [MODE_W-1:0] s_tuser,   // mode
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OW-1:0]          m_tdata,   // data_out, count, zero pad
	output logic [STAT_W-1:0]      m_tuser    // status
);

	localparam int AW = $clog2(DEPTH);

	logic              accept;
	logic              wr_en, rd_en;
	logic [AW-1:0]     addr;
	resp_t             resp;
	logic [CW-1:0]     count;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	logic              valid_s1;
	resp_t             resp_s1;
	logic [CW-1:0]     count_s1;

	logic              out_valid_q;
	logic [DATA_W-1:0] data_out_q;
	logic [STAT_W-1:0] status_q;
	logic [CW-1:0]     count_q;

	logic              out_free, adv_s1;

	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	lsbr_ring #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (accept),
		.mode   (s_tuser),
		.wr_en  (wr_en),
		.rd_en  (rd_en),
		.addr   (addr),
		.resp   (resp),
		.count  (count)
	);

	// read data only changes on an accepted read, so it holds while stage 1 waits
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr] <= s_tdata;
		if (rd_en)
			rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			resp_s1  <= resp;
			count_s1 <= count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_out_q <= resp_s1.rd_used ? rdata_q : '0;
			status_q   <= resp_s1.status;
			count_q    <= count_s1;
		end
	end

	always_comb begin
		m_tdata                = '0;
		m_tdata[DATA_W-1:0]    = data_out_q;
		m_tdata[DATA_W +: CW]  = count_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("read and write issued for one request");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_q <= CW'(DEPTH)))
		else $error("count beyond depth");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (data_out_q == '0))
		else $error("nonzero data on error status");

	a_err_no_access: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && resp.status != ST_OK) |-> (!wr_en && !rd_en))
		else $error("failed request touched memory");

	a_hold_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free && !accept) |=> $stable(rdata_q))
		else $error("read data lost while waiting");

endmodule

`default_nettype wire

/* hdl/lsbr_ring.sv */
`default_nettype none

module lsbr_ring import lsbr_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req,
	input  wire logic [MODE_W-1:0] mode,
	output logic                   wr_en,
	output logic                   rd_en,
	output logic [AW-1:0]          addr,
	output resp_t                  resp,
	output logic [CW-1:0]          count
);

	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [AW-1:0] ONE_A   = AW'(1);

	logic [AW-1:0] base_q, base_d;
	logic          dir_q, dir_d;
	logic [CW-1:0] count_q, count_d;

	logic          full, empty;
	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] top_addr, push_addr, below_addr;
	logic          wr_d, rd_d;
	logic [AW-1:0] addr_d;
	logic [STAT_W-1:0] status_d;

	// logical slot k (0 is the bottom) to physical entry, walking up or down the ring
	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] b, input logic d,
		input logic [AW-1:0] k);
		logic [AW:0] s;
		if (!d)
			s = {1'b0, b} + {1'b0, k};
		else
			s = {1'b0, b} + DEPTH_W - {1'b0, k};
		if (s >= DEPTH_W)
			s = s - DEPTH_W;
		return s[AW-1:0];
	endfunction

	assign full       = (count_q == DEPTH_C);
	assign empty      = (count_q == '0);
	assign cnt_m1     = count_q - ONE_C;
	assign top_addr   = ring_addr(base_q, dir_q, cnt_m1[AW-1:0]);
	assign push_addr  = ring_addr(base_q, dir_q, count_q[AW-1:0]);
	// one slot below the bottom is one slot up in the opposite direction
	assign below_addr = ring_addr(base_q, !dir_q, ONE_A);

	always_comb begin
		base_d   = base_q;
		dir_d    = dir_q;
		count_d  = count_q;
		wr_d     = 1'b0;
		rd_d     = 1'b0;
		addr_d   = top_addr;
		status_d = ST_OK;
		unique case (mode)
			MODE_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_d    = 1'b1;
					addr_d  = push_addr;
					count_d = count_q + ONE_C;
				end
			end
			MODE_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_d    = 1'b1;
					count_d = cnt_m1;
				end
			end
			MODE_PEEK: begin
				if (empty)
					status_d = ST_EMPTY;
				else
					rd_d = 1'b1;
			end
			MODE_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_d    = 1'b1;
					addr_d  = below_addr;
					base_d  = below_addr;
					count_d = count_q + ONE_C;
				end
			end
			MODE_REVERSE: begin
				// the top becomes the bottom and the walk turns around
				if (count_q > ONE_C) begin
					base_d = top_addr;
					dir_d  = !dir_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			dir_q   <= 1'b0;
			count_q <= '0;
		end else if (req) begin
			base_q  <= base_d;
			dir_q   <= dir_d;
			count_q <= count_d;
		end
	end

	assign wr_en        = req && wr_d;
	assign rd_en        = req && rd_d;
	assign addr         = addr_d;
	assign resp.status  = status_d;
	assign resp.rd_used = rd_d;
	assign count        = count_d;

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb import lsbr_pkg::*;;

	localparam int STACK_DEPTH    = 16;
	localparam int CNT_W          = $clog2(STACK_DEPTH + 1);
	localparam int OUT_W          = ((DATA_W + CNT_W + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 1925;

	// mode values the block ignores
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [DATA_W-1:0] word;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count;
	} stack_result_t;

	typedef enum {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} traffic_phase_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;   // data_in
	logic [MODE_W-1:0] s_tuser = '0;   // mode
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;        // data_out, count, zero pad
	logic [STAT_W-1:0] m_tuser;        // status

	bit failed = 1'b0;
	bit no_idle = 1'b0;
	int stall_cycles = 0;

	// shadow copy of the stack contents, entry 0 is the bottom
	logic [DATA_W-1:0] shadow_entries [STACK_DEPTH];
	int                shadow_fill = 0;
	stack_result_t     pending_results [$];

	lifo_stack_with_bottom_insert_reverse #(
		.DEPTH(STACK_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 12);
	end

	task automatic apply_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] word);
		stack_result_t     r;
		logic [DATA_W-1:0] tmp;
		int                lo;
		int                hi;
		r.word   = '0;
		r.status = ST_OK;
		case (mode)
			MODE_PUSH: begin
				if (shadow_fill >= STACK_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_entries[shadow_fill] = word;
					shadow_fill++;
				end
			end
			MODE_POP: begin
				if (shadow_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					shadow_fill--;
					r.word = shadow_entries[shadow_fill];
				end
			end
			MODE_PEEK: begin
				if (shadow_fill == 0)
					r.status = ST_EMPTY;
				else
					r.word = shadow_entries[shadow_fill - 1];
			end
			MODE_INSERT: begin
				if (shadow_fill >= STACK_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = shadow_fill; i > 0; i--)
						shadow_entries[i] = shadow_entries[i - 1];
					shadow_entries[0] = word;
					shadow_fill++;
				end
			end
			MODE_REVERSE: begin
				lo = 0;
				hi = shadow_fill - 1;
				while (lo < hi) begin
					tmp = shadow_entries[lo];
					shadow_entries[lo] = shadow_entries[hi];
					shadow_entries[hi] = tmp;
					lo++;
					hi--;
				end
			end
			default: ;
		endcase
		r.count = shadow_fill[CNT_W-1:0];
		pending_results.push_back(r);
	endtask

	task automatic send_req(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] word);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		apply_request(mode, word);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no request outstanding");
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[DATA_W-1:0] !== want.word) begin
					$error("data_out mismatch: expected %0d, got %0d",
						$signed(want.word), $signed(m_tdata[DATA_W-1:0]));
					failed = 1'b1;
				end
				if (m_tuser !== want.status) begin
					$error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
					failed = 1'b1;
				end
				if (m_tdata[DATA_W +: CNT_W] !== want.count) begin
					$error("count mismatch: expected %0d, got %0d",
						want.count, m_tdata[DATA_W +: CNT_W]);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode(input traffic_phase_t ph);
		int                roll;
		int                grow_pct;
		logic [MODE_W-1:0] m;
		roll = $urandom_range(0, 99);
		grow_pct = (ph == FILL_PHASE) ? 75 : (ph == DRAIN_PHASE) ? 25 : 50;
		if (roll < 6) begin
			m = MODE_UNUSED_LO +
				MODE_W'($urandom_range(0, MODE_UNUSED_HI - MODE_UNUSED_LO));
		end else if (roll < 16) begin
			m = MODE_REVERSE;
		end else if ($urandom_range(0, 99) < grow_pct) begin
			m = $urandom_range(0, 1) ? MODE_PUSH : MODE_INSERT;
		end else begin
			m = ($urandom_range(0, 99) < 65) ? MODE_POP : MODE_PEEK;
		end
		return m;
	endfunction

	task automatic test_empty_stack();
		send_req(MODE_POP, 32'h1234_5678);
		send_req(MODE_PEEK, '1);
		send_req(MODE_REVERSE, '0);
		send_req(MODE_UNUSED_LO, 32'hdead_beef);
	endtask

	task automatic test_single_entry();
		send_req(MODE_PUSH, 32'h7fff_ffff);
		send_req(MODE_REVERSE, 32'h5555_5555);
		send_req(MODE_PEEK, '0);
	endtask

	// one entry is already stored, fill the rest with a mix of top and bottom writes
	task automatic test_full_stack();
		for (int i = 1; i < STACK_DEPTH; i++) begin
			if (i % 2)
				send_req(MODE_INSERT, 32'h8000_0000 | i);
			else
				send_req(MODE_PUSH, 32'h7fff_0000 | i);
		end
		send_req(MODE_PUSH, '0);
		send_req(MODE_INSERT, '1);
		send_req(MODE_REVERSE, '0);
		send_req(MODE_POP, '0);
	endtask

	task automatic test_random_traffic(input int n_items);
		traffic_phase_t ph;
		int             sent;
		int             len;
		int             phase_no;
		sent = 0;
		phase_no = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 2))
				0: ph = FILL_PHASE;
				1: ph = DRAIN_PHASE;
				default: ph = MIXED_PHASE;
			endcase
			len = $urandom_range(10, 50);
			// one long stretch where neither side backs off
			no_idle = (phase_no == 8);
			if (no_idle)
				len = 250;
			for (int k = 0; k < len && sent < n_items; k++) begin
				send_req(pick_mode(ph), pick_word());
				sent++;
			end
			if (phase_no % 6 == 5)
				wait_results_drained();
			phase_no++;
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_stack();
		test_single_entry();
		test_full_stack();
		wait_results_drained();
		test_random_traffic(RANDOM_ITEMS);
		wait_results_drained();
		repeat (4) @(posedge clk);
		if (failed)
			$display("FAIL");
		else
			$display("PASS");
		$finish;
	end

endmodule

/* files.f */
hdl/lsbr_pkg.sv
hdl/lsbr_ring.sv
hdl/lifo_stack_with_bottom_insert_reverse.sv
verif/tb.sv
